[hw/rtl/arlh_pkg.sv]
// shared constants and types for the auto-range log histogram
package arlh_pkg;

    localparam int DEF_MAX_POINTS    = 16384;
    localparam int DEF_MAX_BINS      = 64;
    localparam int DEF_SAMPLE_BITS   = 24;
    localparam int DEF_LOG_FRAC_BITS = 12;

    localparam int CNT_W     = 15;
    localparam int IDX_W     = 6;
    localparam int LOG_W     = 15;
    localparam int BINCNT_W  = 7;
    localparam int CFG_DATA_W = 24;
    localparam int CFG_IDX_W = 1;

    localparam logic [CFG_IDX_W-1:0] REG_NO_DATA   = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_BIN_COUNT = 1'd1;

    localparam logic [CNT_W-1:0] CNT_SAT = {CNT_W{1'b1}};
    localparam logic [LOG_W-1:0] LOG_SAT = {LOG_W{1'b1}};
    localparam logic [31:0] LOG10_2_Q32 = 32'd1292913986;

    // handshake between the binning sequencer and the log unit
    typedef struct packed {
        logic             start;
        logic [CNT_W-1:0] count;
    } log_req_t;

    typedef struct packed {
        logic             done;
        logic [LOG_W-1:0] value;
    } log_rsp_t;

endpackage

[hw/rtl/arlh_log10.sv]
// iterative fixed-point log10 of a bin count, one squaring step per cycle
module arlh_log10
    import arlh_pkg::*;
#(
    parameter int LOG_FRAC_BITS = DEF_LOG_FRAC_BITS
) (
    input  logic     aclk,
    input  logic     aresetn,
    input  log_req_t req,
    output log_rsp_t rsp
);
    typedef enum logic [3:0] {
        L_IDLE = 4'b0001,
        L_NORM = 4'b0010,
        L_SQR  = 4'b0100,
        L_MUL  = 4'b1000
    } lstate_t;

    localparam int EXP_W = 4;
    localparam int SH = 56 - LOG_FRAC_BITS;

    lstate_t          state_reg, state_next;
    logic [4:0]       step_reg, step_next;
    logic [31:0]      man_reg, man_next;   // Q1.30 in [1,2)
    logic [27:0]      l2_reg, l2_next;     // Q4.24
    logic [CNT_W-1:0] n_reg, n_next;
    logic [59:0]      prod_reg, prod_next;
    logic [LOG_W-1:0] res_reg, res_next;
    logic             done_reg, done_next;

    logic [63:0] sq;
    logic [EXP_W-1:0] msb;
    logic [59:0] rnd;

    assign sq = {32'd0, man_reg} * {32'd0, man_reg};

    always_comb begin
        msb = '0;
        for (int b = 0; b < CNT_W; b++) begin
            if (n_reg[b]) msb = EXP_W'(b);
        end
    end

    assign rnd = (prod_reg + (60'd1 << (SH - 1))) >> SH;

    always_comb begin
        state_next = state_reg;
        step_next  = step_reg;
        man_next   = man_reg;
        l2_next    = l2_reg;
        n_next     = n_reg;
        prod_next  = prod_reg;
        res_next   = res_reg;
        done_next  = 1'b0;
        unique case (state_reg)
            L_IDLE: begin
                if (req.start) begin
                    n_next = req.count;
                    if (req.count == '0) begin
                        res_next  = '0;
                        done_next = 1'b1;
                    end else begin
                        state_next = L_NORM;
                    end
                end
            end
            L_NORM: begin
                man_next   = 32'({17'd0, n_reg} << (30 - int'(msb)));
                l2_next    = {msb, 24'd0};
                step_next  = '0;
                state_next = L_SQR;
            end
            L_SQR: begin
                if (sq[61]) begin
                    man_next = sq[62:31];
                    l2_next  = l2_reg | (28'd1 << (23 - int'(step_reg)));
                end else begin
                    man_next = sq[61:30];
                end
                step_next = step_reg + 5'd1;
                if (step_reg == 5'd23) state_next = L_MUL;
            end
            L_MUL: begin
                prod_next  = 60'(l2_reg) * 60'(LOG10_2_Q32);
                state_next = L_IDLE;
                step_next  = 5'd31;
            end
            default: state_next = L_IDLE;
        endcase
        // rounding in the cycle after the product is registered
        if (state_reg == L_IDLE && step_reg == 5'd31) begin
            step_next = '0;
            res_next  = (rnd > 60'(LOG_SAT)) ? LOG_SAT : LOG_W'(rnd);
            done_next = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= L_IDLE;
            step_reg  <= '0;
            done_reg  <= 1'b0;
        end else begin
            state_reg <= state_next;
            step_reg  <= step_next;
            done_reg  <= done_next;
        end
        man_reg  <= man_next;
        l2_reg   <= l2_next;
        n_reg    <= n_next;
        prod_reg <= prod_next;
        res_reg  <= res_next;
    end

    assign rsp.done  = done_reg;
    assign rsp.value = res_reg;
endmodule

[hw/rtl/arlh_divider.sv]
// restoring divider for the bin index, one quotient bit per cycle
module arlh_divider
    import arlh_pkg::*;
#(
    parameter int NUM_W = 40,
    parameter int DEN_W = 33
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             start,
    input  logic [NUM_W-1:0] num,
    input  logic [DEN_W-1:0] den,
    output logic             done,
    output logic [NUM_W-1:0] quot
);
    localparam int CW = $clog2(NUM_W + 1);

    logic [CW-1:0]    cnt_reg, cnt_next;
    logic             busy_reg, busy_next, done_reg, done_next;
    logic [NUM_W-1:0] q_reg, q_next;
    logic [DEN_W:0]   rem_reg, rem_next;
    logic [DEN_W-1:0] den_reg, den_next;
    logic [DEN_W:0]   trial;

    assign trial = {rem_reg[DEN_W-1:0], q_reg[NUM_W-1]};

    always_comb begin
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        q_next    = q_reg;
        rem_next  = rem_reg;
        den_next  = den_reg;
        if (start) begin
            busy_next = 1'b1;
            cnt_next  = CW'(NUM_W);
            q_next    = num;
            rem_next  = '0;
            den_next  = den;
        end else if (busy_reg) begin
            if (trial >= {1'b0, den_reg}) begin
                rem_next = trial - {1'b0, den_reg};
                q_next   = {q_reg[NUM_W-2:0], 1'b1};
            end else begin
                rem_next = trial;
                q_next   = {q_reg[NUM_W-2:0], 1'b0};
            end
            cnt_next = cnt_reg - CW'(1);
            if (cnt_reg == CW'(1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
        q_reg   <= q_next;
        rem_reg <= rem_next;
        den_reg <= den_next;
    end

    assign done = done_reg;
    assign quot = q_reg;
endmodule

[hw/rtl/auto_range_log_histogram.sv]
// auto-ranging histogram with log10 bin heights: top level and sequencer
//
// usage:
//   samples enter on s_valid/s_ready with s_sample and s_last_sample; one item
//   is taken per cycle while the set is loading. samples equal to the no-data
//   register are skipped, others go to the sample memory (up to MAX_POINTS).
//   after the item flagged last the block stops taking items and runs:
//   a binning pass over the memory (read, one serial divide of 32 quotient
//   steps per sample, read-modify-write of the count memory), then per bin
//   a log10, first to find the peak and again to emit. results leave on
//   m_valid/m_ready, one per bin in use, last_bin on the final one; a flat
//   or empty set gives a single result with status 1. the serial divider
//   sets the pace of the binning pass, and no new items are taken until the
//   last result has gone. a stalled receiver holds the output register and
//   the sequencer waits. reset (aresetn low, synchronous) sets no_data_value
//   0, bin_count 64, then clears the count memory in a pass over all MAX_BINS
//   entries with s_ready low; later sets clear their counts bin by bin during
//   the output pass. config is written with cfg_we/cfg_index/cfg_data while
//   idle; the user must keep to this, as the block itself does not enforce it.
module auto_range_log_histogram
    import arlh_pkg::*;
#(
    parameter int MAX_POINTS    = DEF_MAX_POINTS,
    parameter int MAX_BINS      = DEF_MAX_BINS,
    parameter int SAMPLE_BITS   = DEF_SAMPLE_BITS,
    parameter int LOG_FRAC_BITS = DEF_LOG_FRAC_BITS
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    input  logic                  s_valid,
    output logic                  s_ready,
    input  logic [SAMPLE_BITS-1:0] s_sample,
    input  logic                  s_last_sample,
    output logic                  m_valid,
    input  logic                  m_ready,
    output logic [IDX_W-1:0]      m_bin_index,
    output logic [CNT_W-1:0]      m_bin_total,
    output logic [LOG_W-1:0]      m_log_total,
    output logic [LOG_W-1:0]      m_peak_log,
    output logic [SAMPLE_BITS-1:0] m_range_low,
    output logic [SAMPLE_BITS-1:0] m_range_high,
    output logic                  m_status,
    output logic                  m_last_bin
);
    localparam int AW   = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
    localparam int PCW  = $clog2(MAX_POINTS + 1);
    localparam int BW   = (MAX_BINS > 1) ? $clog2(MAX_BINS) : 1;
    localparam int DW   = SAMPLE_BITS + 1;
    localparam int NUMW = DW + BINCNT_W;

    typedef enum logic [11:0] {
        S_LOAD  = 12'b000000000001,
        S_RD    = 12'b000000000010,
        S_DIVGO = 12'b000000000100,
        S_DIVW  = 12'b000000001000,
        S_CRD   = 12'b000000010000,
        S_CWR   = 12'b000000100000,
        S_PRD   = 12'b000001000000,
        S_PLOG  = 12'b000010000000,
        S_ORD   = 12'b000100000000,
        S_OLOG  = 12'b001000000000,
        S_OUT   = 12'b010000000000,
        S_CLR   = 12'b100000000000
    } state_t;

    state_t state_reg, state_next;

    logic signed [SAMPLE_BITS-1:0] nodata_reg;
    logic [BINCNT_W-1:0]           bincfg_reg;

    // memories
    logic signed [SAMPLE_BITS-1:0] smem [MAX_POINTS];
    logic [CNT_W-1:0]              cmem [MAX_BINS];
    logic signed [SAMPLE_BITS-1:0] srd_reg;
    logic [CNT_W-1:0]              crd_reg;

    logic [PCW-1:0] stored_reg, stored_next;
    logic [PCW-1:0] ptr_reg, ptr_next;
    logic signed [SAMPLE_BITS-1:0] min_reg, min_next, max_reg, max_next;
    logic seen_reg, seen_next;
    logic [BW-1:0]  bin_reg, bin_next;
    logic [BINCNT_W-1:0] bins_reg, bins_next;
    logic [LOG_W-1:0] peak_reg, peak_next;
    logic [BW-1:0]  jbin_reg, jbin_next;

    logic mv_reg, mv_next;
    logic [IDX_W-1:0] o_idx_reg, o_idx_next;
    logic [CNT_W-1:0] o_tot_reg, o_tot_next;
    logic [LOG_W-1:0] o_log_reg, o_log_next;
    logic o_stat_reg, o_stat_next, o_last_reg, o_last_next;

    logic s_acc, is_valid, room;
    logic swe, cwe;
    logic [AW-1:0] saddr_rd;
    logic [BW-1:0] caddr_rd, caddr_wr;
    logic [CNT_W-1:0] cwdata;

    logic div_start, div_done;
    logic [NUMW-1:0] div_num, div_q;
    logic [DW-1:0]   div_den;
    log_req_t lreq;
    log_rsp_t lrsp;

    logic [BINCNT_W-1:0] bins_eff;
    always_comb begin
        if (bincfg_reg == '0)
            bins_eff = BINCNT_W'(1);
        else if (bincfg_reg > BINCNT_W'(MAX_BINS))
            bins_eff = BINCNT_W'(MAX_BINS);
        else
            bins_eff = bincfg_reg;
    end

    assign s_ready  = (state_reg == S_LOAD);
    assign s_acc    = s_valid && s_ready;
    assign is_valid = (s_sample != nodata_reg);
    assign room     = (stored_reg < PCW'(MAX_POINTS));
    assign swe      = s_acc && is_valid && room;

    // (x-min)*bins and (max-min), both nonnegative
    logic [DW-1:0] diff_x;
    assign diff_x  = DW'({srd_reg[SAMPLE_BITS-1], srd_reg}
                         - {min_reg[SAMPLE_BITS-1], min_reg});
    assign div_den = DW'({max_reg[SAMPLE_BITS-1], max_reg}
                         - {min_reg[SAMPLE_BITS-1], min_reg});
    assign div_num = NUMW'(diff_x) * NUMW'(bins_reg);

    logic [NUMW-1:0] jclip;
    assign jclip = (div_q >= NUMW'(bins_reg)) ? NUMW'(bins_reg - BINCNT_W'(1)) : div_q;

    always_comb begin
        state_next  = state_reg;
        stored_next = stored_reg;
        ptr_next    = ptr_reg;
        min_next    = min_reg;
        max_next    = max_reg;
        seen_next   = seen_reg;
        bin_next    = bin_reg;
        bins_next   = bins_reg;
        peak_next   = peak_reg;
        jbin_next   = jbin_reg;
        mv_next     = mv_reg;
        o_idx_next  = o_idx_reg;
        o_tot_next  = o_tot_reg;
        o_log_next  = o_log_reg;
        o_stat_next = o_stat_reg;
        o_last_next = o_last_reg;
        saddr_rd    = ptr_reg[AW-1:0];
        caddr_rd    = bin_reg;
        caddr_wr    = jbin_reg;
        cwe         = 1'b0;
        cwdata      = '0;
        div_start   = 1'b0;
        lreq.start  = 1'b0;
        lreq.count  = crd_reg;

        if (mv_reg && m_ready) mv_next = 1'b0;

        unique case (state_reg)
            S_CLR: begin
                cwe      = 1'b1;
                caddr_wr = bin_reg;
                cwdata   = '0;
                bin_next = bin_reg + BW'(1);
                if (BINCNT_W'(bin_reg) == BINCNT_W'(MAX_BINS - 1)) begin
                    bin_next   = '0;
                    state_next = S_LOAD;
                end
            end
            S_LOAD: begin
                if (swe) begin
                    stored_next = stored_reg + PCW'(1);
                    if (!seen_reg) begin
                        min_next = s_sample;
                        max_next = s_sample;
                    end else begin
                        if ($signed(s_sample) < min_reg) min_next = s_sample;
                        if ($signed(s_sample) > max_reg) max_next = s_sample;
                    end
                    seen_next = 1'b1;
                end
                if (s_acc && s_last_sample) begin
                    bins_next = bins_eff;
                    ptr_next  = '0;
                    bin_next  = '0;
                    peak_next = '0;
                    if (!seen_next || min_next == max_next) begin
                        // flat or empty set
                        mv_next     = 1'b1;
                        o_idx_next  = '0;
                        o_tot_next  = '0;
                        o_log_next  = '0;
                        o_stat_next = 1'b1;
                        o_last_next = 1'b1;
                        state_next  = S_OUT;
                    end else begin
                        state_next = S_RD;
                    end
                end
            end
            S_RD: begin
                if (ptr_reg == stored_reg) begin
                    state_next = S_PRD;
                end else begin
                    state_next = S_DIVGO;
                end
            end
            S_DIVGO: begin
                div_start  = 1'b1;
                state_next = S_DIVW;
            end
            S_DIVW: begin
                if (div_done) begin
                    jbin_next  = BW'(jclip);
                    caddr_rd   = BW'(jclip);
                    state_next = S_CRD;
                end
            end
            S_CRD: begin
                caddr_rd   = jbin_reg;
                state_next = S_CWR;
            end
            S_CWR: begin
                cwe    = 1'b1;
                cwdata = (crd_reg == CNT_SAT) ? crd_reg : crd_reg + CNT_W'(1);
                ptr_next   = ptr_reg + PCW'(1);
                saddr_rd   = AW'(ptr_reg + PCW'(1));
                state_next = S_RD;
            end
            S_PRD: begin
                lreq.start = 1'b1;
                state_next = S_PLOG;
            end
            S_PLOG: begin
                if (lrsp.done) begin
                    if (lrsp.value > peak_reg) peak_next = lrsp.value;
                    if (BINCNT_W'(bin_reg) == bins_reg - BINCNT_W'(1)) begin
                        bin_next   = '0;
                        caddr_rd   = '0;
                        state_next = S_ORD;
                    end else begin
                        bin_next   = bin_reg + BW'(1);
                        caddr_rd   = bin_reg + BW'(1);
                        state_next = S_PRD;
                    end
                end
            end
            S_ORD: begin
                lreq.start = 1'b1;
                state_next = S_OLOG;
            end
            S_OLOG: begin
                if (lrsp.done && !mv_next) begin
                    mv_next     = 1'b1;
                    o_idx_next  = IDX_W'(bin_reg);
                    o_tot_next  = crd_reg;
                    o_log_next  = lrsp.value;
                    o_stat_next = 1'b0;
                    o_last_next = (BINCNT_W'(bin_reg) == bins_reg - BINCNT_W'(1));
                    // clear the count for the next set
                    cwe      = 1'b1;
                    caddr_wr = bin_reg;
                    cwdata   = '0;
                    state_next = S_OUT;
                end
            end
            S_OUT: begin
                if (!mv_next) begin
                    if (o_last_reg) begin
                        stored_next = '0;
                        min_next    = '0;
                        max_next    = '0;
                        seen_next   = 1'b0;
                        state_next  = S_LOAD;
                    end else begin
                        bin_next   = bin_reg + BW'(1);
                        caddr_rd   = bin_reg + BW'(1);
                        state_next = S_ORD;
                    end
                end
            end
            default: state_next = S_LOAD;
        endcase
    end

    // the log result is taken in S_OLOG as it arrives; the output register is free
    // by then, since S_OUT moves on only after the previous result has been taken
    always_ff @(posedge aclk) begin
        if (swe) smem[stored_reg[AW-1:0]] <= s_sample;
        srd_reg <= smem[saddr_rd];
    end

    always_ff @(posedge aclk) begin
        if (cwe) cmem[caddr_wr] <= cwdata;
        crd_reg <= cmem[caddr_rd];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg  <= S_CLR;
            stored_reg <= '0;
            min_reg    <= '0;
            max_reg    <= '0;
            seen_reg   <= 1'b0;
            mv_reg     <= 1'b0;
            bin_reg    <= '0;
            nodata_reg <= '0;
            bincfg_reg <= BINCNT_W'(64);
        end else begin
            state_reg  <= state_next;
            stored_reg <= stored_next;
            min_reg    <= min_next;
            max_reg    <= max_next;
            seen_reg   <= seen_next;
            mv_reg     <= mv_next;
            bin_reg    <= bin_next;
            if (cfg_we) begin
                unique case (cfg_index)
                    REG_NO_DATA:   nodata_reg <= SAMPLE_BITS'(signed'(cfg_data));
                    REG_BIN_COUNT: bincfg_reg <= cfg_data[BINCNT_W-1:0];
                    default: ;
                endcase
            end
        end
        ptr_reg    <= ptr_next;
        bins_reg   <= bins_next;
        peak_reg   <= peak_next;
        jbin_reg   <= jbin_next;
        o_idx_reg  <= o_idx_next;
        o_tot_reg  <= o_tot_next;
        o_log_reg  <= o_log_next;
        o_stat_reg <= o_stat_next;
        o_last_reg <= o_last_next;
    end

    arlh_divider #(.NUM_W(NUMW), .DEN_W(DW)) u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (div_start),
        .num     (div_num),
        .den     (div_den),
        .done    (div_done),
        .quot    (div_q)
    );

    arlh_log10 #(.LOG_FRAC_BITS(LOG_FRAC_BITS)) u_log (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (lreq),
        .rsp     (lrsp)
    );

    assign m_valid      = mv_reg;
    assign m_bin_index  = o_idx_reg;
    assign m_bin_total  = o_tot_reg;
    assign m_log_total  = o_log_reg;
    assign m_peak_log   = o_stat_reg ? '0 : peak_reg;
    assign m_range_low  = min_reg;
    assign m_range_high = max_reg;
    assign m_status     = o_stat_reg;
    assign m_last_bin   = o_last_reg;
endmodule
